// ----- hdl/cbb_pkg.sv -----
`default_nettype none

package cbb_pkg;

   localparam int unsigned CNT_W = 3;
   localparam logic [CNT_W-1:0] SEEN_MAX = 3'd7;

   // point roles within a segment job
   localparam logic [1:0] PT_A = 2'd0;
   localparam logic [1:0] PT_B = 2'd1;
   localparam logic [1:0] PT_C = 2'd2;
   localparam logic [1:0] PT_D = 2'd3;

   // point roles within a result segment
   localparam logic [1:0] SEG_START  = 2'd0;
   localparam logic [1:0] SEG_CTRL_A = 2'd1;
   localparam logic [1:0] SEG_CTRL_B = 2'd2;
   localparam logic [1:0] SEG_END    = 2'd3;

   localparam logic CRD_X = 1'b0;
   localparam logic CRD_Y = 1'b1;

   typedef enum logic [2:0] {
      SRC_OLDER,
      SRC_W0,
      SRC_W1,
      SRC_W2,
      SRC_H0,
      SRC_H1,
      SRC_H2,
      SRC_CUR
   } src_type;

   typedef struct packed {
      logic first;
      logic last;
      logic prev_first;
      logic next_last;
      logic last_seg;
   } seg_flags_type;

   typedef struct packed {
      src_type       a;
      src_type       b;
      src_type       c;
      src_type       d;
      seg_flags_type flags;
   } job_type;

   typedef struct packed {
      logic             item_valid;
      logic             item_done;
      logic             wrap_pending;
      logic [CNT_W-1:0] seen;
   } ctrl_status_type;

endpackage

`default_nettype wire

// ----- hdl/cubic_bspline_to_bezier.sv -----
// a point's first segment passes the held-point, stage-one and output registers
// one point per cycle unless stalled; an n-segment point holds the input until all are sent
// a closed spline's final segment leaves with the first point of the next spline
// reset is synchronous: open mode, empty window, zero count; head store not cleared
`default_nettype none

module cubic_bspline_to_bezier
   import cbb_pkg::*;
#(
   parameter int unsigned COORD_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic                          csr_wr_data,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [COORD_WIDTH-1:0] req_point_x,
   input  logic signed [COORD_WIDTH-1:0] req_point_y,
   input  logic                          req_last_point,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [COORD_WIDTH-1:0] rsp_start_x,
   output logic signed [COORD_WIDTH-1:0] rsp_start_y,
   output logic signed [COORD_WIDTH-1:0] rsp_ctrl_a_x,
   output logic signed [COORD_WIDTH-1:0] rsp_ctrl_a_y,
   output logic signed [COORD_WIDTH-1:0] rsp_ctrl_b_x,
   output logic signed [COORD_WIDTH-1:0] rsp_ctrl_b_y,
   output logic signed [COORD_WIDTH-1:0] rsp_end_x,
   output logic signed [COORD_WIDTH-1:0] rsp_end_y,
   output logic                          rsp_last_segment
);

   logic                             adv;
   logic                             job_valid;
   seg_flags_type                    job_flags;
   logic [1:0][3:0][COORD_WIDTH-1:0] job_pt;
   logic [1:0][3:0][COORD_WIDTH-1:0] rsp_pt;
   ctrl_status_type                  status;

   cbb_ctrl #(.COORD_WIDTH(COORD_WIDTH)) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_valid      (req_valid),
      .req_point_x    (req_point_x),
      .req_point_y    (req_point_y),
      .req_last_point (req_last_point),
      .adv            (adv),
      .job_valid      (job_valid),
      .job_flags      (job_flags),
      .job_pt         (job_pt),
      .status         (status)
   );

   cbb_seg_pipe #(.COORD_WIDTH(COORD_WIDTH)) u_seg_pipe (
      .clock            (clock),
      .reset            (reset),
      .job_valid        (job_valid),
      .job_flags        (job_flags),
      .job_pt           (job_pt),
      .rsp_ready        (rsp_ready),
      .adv              (adv),
      .rsp_valid        (rsp_valid),
      .rsp_last_segment (rsp_last_segment),
      .rsp_pt           (rsp_pt)
   );

   assign req_ready = !reset && (!status.item_valid || status.item_done);

   assign rsp_start_x  = rsp_pt[CRD_X][SEG_START];
   assign rsp_start_y  = rsp_pt[CRD_Y][SEG_START];
   assign rsp_ctrl_a_x = rsp_pt[CRD_X][SEG_CTRL_A];
   assign rsp_ctrl_a_y = rsp_pt[CRD_Y][SEG_CTRL_A];
   assign rsp_ctrl_b_x = rsp_pt[CRD_X][SEG_CTRL_B];
   assign rsp_ctrl_b_y = rsp_pt[CRD_Y][SEG_CTRL_B];
   assign rsp_end_x    = rsp_pt[CRD_X][SEG_END];
   assign rsp_end_y    = rsp_pt[CRD_Y][SEG_END];

`ifndef SYNTHESIS
   a_wrap_at_spline_start: assert property (@(posedge clock) disable iff (reset)
      status.wrap_pending |-> (status.seen == '0))
      else $error("wrap segment pending inside a spline");

   a_item_held: assert property (@(posedge clock) disable iff (reset)
      (status.item_valid && !status.item_done) |=> status.item_valid)
      else $error("point dropped before its segments were issued");

   a_wrap_after_long_spline: assert property (@(posedge clock) disable iff (reset)
      $rose(status.wrap_pending) |-> ($past(status.seen) >= 3'd3))
      else $error("wrap segment owed by a short spline");
`endif

endmodule

`default_nettype wire

// ----- hdl/cbb_thirds.sv -----
`default_nettype none

module cbb_thirds #(
   parameter int unsigned COORD_WIDTH = 32
) (
   input  logic [COORD_WIDTH-1:0] near_v,
   input  logic [COORD_WIDTH-1:0] far_v,
   output logic [COORD_WIDTH-1:0] quot
);

   localparam int unsigned SW = COORD_WIDTH + 2;
   localparam int unsigned ND = (COORD_WIDTH + 3) / 2;
   localparam int unsigned MW = 2 * ND;
   localparam int unsigned LV = $clog2(ND);

   function automatic logic [1:0] mod3_digit(input logic [1:0] d);
      mod3_digit = (d == 2'd3) ? 2'd0 : d;
   endfunction

   function automatic logic [1:0] mod3_add(input logic [1:0] p, input logic [1:0] q);
      logic [2:0] s;
      s = {1'b0, p} + {1'b0, q};
      mod3_add = (s >= 3'd3) ? 2'(s - 3'd3) : s[1:0];
   endfunction

   // quotient digit of (4 * rem + digit) / 3
   function automatic logic [1:0] quot_digit(input logic [1:0] r, input logic [1:0] d);
      logic [3:0] t;
      t = {r, d};
      case (t) inside
         [4'd0:4'd2]:  quot_digit = 2'd0;
         [4'd3:4'd5]:  quot_digit = 2'd1;
         [4'd6:4'd8]:  quot_digit = 2'd2;
         default:      quot_digit = 2'd3;
      endcase
   endfunction

   logic [SW-1:0] sum;
   logic          neg;
   logic [SW-1:0] mag;
   logic [MW-1:0] dig_v;
   logic [MW-1:0] qres;
   wire  [MW-1:0] qmag;
   wire  [1:0]    pre [0:LV][0:ND-1];

   assign sum   = {near_v[COORD_WIDTH-1], near_v, 1'b0}
                + {{2{far_v[COORD_WIDTH-1]}}, far_v};
   assign neg   = sum[SW-1];
   assign mag   = neg ? (~sum + 1'b1) : sum;
   assign dig_v = MW'(mag);

   // prefix remainders over base-4 digits, most significant first (4 = 1 mod 3)
   for (genvar j = 0; j < ND; j++) begin : g_leaf
      assign pre[0][j] = mod3_digit(dig_v[2*(ND-1-j) +: 2]);
   end

   for (genvar lv = 0; lv < LV; lv++) begin : g_lvl
      for (genvar j = 0; j < ND; j++) begin : g_node
         if (j >= (1 << lv)) begin : g_add
            assign pre[lv+1][j] = mod3_add(pre[lv][j], pre[lv][j-(1<<lv)]);
         end else begin : g_pass
            assign pre[lv+1][j] = pre[lv][j];
         end
      end
   end

   for (genvar j = 0; j < ND; j++) begin : g_quo
      if (j == 0) begin : g_top
         assign qmag[2*(ND-1-j) +: 2] = quot_digit(2'd0, dig_v[2*(ND-1-j) +: 2]);
      end else begin : g_rest
         assign qmag[2*(ND-1-j) +: 2] = quot_digit(pre[LV][j-1], dig_v[2*(ND-1-j) +: 2]);
      end
   end

   assign qres = neg ? (~qmag + 1'b1) : qmag;
   assign quot = qres[COORD_WIDTH-1:0];

endmodule

`default_nettype wire

// ----- hdl/cbb_seg_pipe.sv -----
`default_nettype none

module cbb_seg_pipe
   import cbb_pkg::*;
#(
   parameter int unsigned COORD_WIDTH = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               job_valid,
   input  seg_flags_type                      job_flags,
   input  logic [1:0][3:0][COORD_WIDTH-1:0]   job_pt,
   input  logic                               rsp_ready,
   output logic                               adv,
   output logic                               rsp_valid,
   output logic                               rsp_last_segment,
   output logic [1:0][3:0][COORD_WIDTH-1:0]   rsp_pt
);

   // (u + v) / 2 truncated toward zero
   function automatic logic [COORD_WIDTH-1:0] half_pt(input logic [COORD_WIDTH-1:0] u,
                                                      input logic [COORD_WIDTH-1:0] v);
      logic [COORD_WIDTH:0] s;
      logic [COORD_WIDTH:0] r;
      s = {u[COORD_WIDTH-1], u} + {v[COORD_WIDTH-1], v};
      r = s + {{COORD_WIDTH{1'b0}}, s[COORD_WIDTH]};
      half_pt = r[COORD_WIDTH:1];
   endfunction

   wire  [1:0][COORD_WIDTH-1:0] th_bc;
   wire  [1:0][COORD_WIDTH-1:0] th_cb;
   wire  [1:0][COORD_WIDTH-1:0] th_ba;
   wire  [1:0][COORD_WIDTH-1:0] th_cd;

   logic                        s1_valid_ff, s1_valid_in;
   seg_flags_type               s1_flags_ff;
   logic [1:0][COORD_WIDTH-1:0] c1_ff, c1_in;
   logic [1:0][COORD_WIDTH-1:0] c2_ff, c2_in;
   logic [1:0][COORD_WIDTH-1:0] pj_ff, pj_in;
   logic [1:0][COORD_WIDTH-1:0] nj_ff, nj_in;
   logic [1:0][COORD_WIDTH-1:0] a_ff, a_in;
   logic [1:0][COORD_WIDTH-1:0] d_ff, d_in;

   logic                           out_valid_ff, out_valid_in;
   logic                           out_last_ff;
   logic [1:0][3:0][COORD_WIDTH-1:0] out_pt_ff, out_pt_in;

   for (genvar c = 0; c < 2; c++) begin : g_crd
      cbb_thirds #(.COORD_WIDTH(COORD_WIDTH)) u_th_bc (
         .near_v (job_pt[c][PT_B]),
         .far_v  (job_pt[c][PT_C]),
         .quot   (th_bc[c])
      );
      cbb_thirds #(.COORD_WIDTH(COORD_WIDTH)) u_th_cb (
         .near_v (job_pt[c][PT_C]),
         .far_v  (job_pt[c][PT_B]),
         .quot   (th_cb[c])
      );
      cbb_thirds #(.COORD_WIDTH(COORD_WIDTH)) u_th_ba (
         .near_v (job_pt[c][PT_B]),
         .far_v  (job_pt[c][PT_A]),
         .quot   (th_ba[c])
      );
      cbb_thirds #(.COORD_WIDTH(COORD_WIDTH)) u_th_cd (
         .near_v (job_pt[c][PT_C]),
         .far_v  (job_pt[c][PT_D]),
         .quot   (th_cd[c])
      );
   end

   assign adv = !out_valid_ff || rsp_ready;

   // inner controls and neighbouring thirds
   always_comb begin
      logic [COORD_WIDTH-1:0] h_bc;
      for (int c = 0; c < 2; c++) begin
         h_bc = half_pt(job_pt[c][PT_B], job_pt[c][PT_C]);
         c1_in[c] = job_flags.first ? job_pt[c][PT_B]
                  : (job_flags.last ? h_bc : th_bc[c]);
         c2_in[c] = job_flags.last ? job_pt[c][PT_C]
                  : (job_flags.first ? h_bc : th_cb[c]);
         pj_in[c] = job_flags.prev_first ? half_pt(job_pt[c][PT_A], job_pt[c][PT_B])
                  : th_ba[c];
         nj_in[c] = job_flags.next_last ? half_pt(job_pt[c][PT_C], job_pt[c][PT_D])
                  : th_cd[c];
         a_in[c]  = job_pt[c][PT_A];
         d_in[c]  = job_pt[c][PT_D];
      end
   end

   // junctions
   always_comb begin
      for (int c = 0; c < 2; c++) begin
         out_pt_in[c][SEG_START]  = s1_flags_ff.first ? a_ff[c] : half_pt(pj_ff[c], c1_ff[c]);
         out_pt_in[c][SEG_CTRL_A] = c1_ff[c];
         out_pt_in[c][SEG_CTRL_B] = c2_ff[c];
         out_pt_in[c][SEG_END]    = s1_flags_ff.last ? d_ff[c] : half_pt(c2_ff[c], nj_ff[c]);
      end
   end

   assign s1_valid_in  = adv ? job_valid : s1_valid_ff;
   assign out_valid_in = adv ? s1_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_flags_ff <= job_flags;
         c1_ff       <= c1_in;
         c2_ff       <= c2_in;
         pj_ff       <= pj_in;
         nj_ff       <= nj_in;
         a_ff        <= a_in;
         d_ff        <= d_in;
         out_pt_ff   <= out_pt_in;
         out_last_ff <= s1_flags_ff.last_seg;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_last_segment = out_last_ff;
   assign rsp_pt           = out_pt_ff;

endmodule

`default_nettype wire

// ----- hdl/cbb_ctrl.sv -----
`default_nettype none

module cbb_ctrl
   import cbb_pkg::*;
#(
   parameter int unsigned COORD_WIDTH = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic                             csr_wr_data,
   input  logic                             req_valid,
   input  logic [COORD_WIDTH-1:0]           req_point_x,
   input  logic [COORD_WIDTH-1:0]           req_point_y,
   input  logic                             req_last_point,
   input  logic                             adv,
   output logic                             job_valid,
   output seg_flags_type                    job_flags,
   output logic [1:0][3:0][COORD_WIDTH-1:0] job_pt,
   output ctrl_status_type                  status
);

   logic                        mode_ff, mode_in;
   logic                        item_valid_ff, item_valid_in;
   logic [COORD_WIDTH-1:0]      item_x_ff, item_y_ff;
   logic                        item_last_ff;
   logic [2:0][COORD_WIDTH-1:0] win_x_ff, win_x_in;
   logic [2:0][COORD_WIDTH-1:0] win_y_ff, win_y_in;
   logic [COORD_WIDTH-1:0]      older_x_ff, older_x_in;
   logic [COORD_WIDTH-1:0]      older_y_ff, older_y_in;
   logic [2:0][COORD_WIDTH-1:0] head_x_ff, head_x_in;
   logic [2:0][COORD_WIDTH-1:0] head_y_ff, head_y_in;
   logic [CNT_W-1:0]            seen_ff, seen_in;
   logic                        wrap_ff, wrap_in;
   logic [1:0]                  job_idx_ff, job_idx_in;

   job_type    job;
   logic [1:0] job_cnt;
   logic       last_job;
   logic       issue;
   logic       done;
   logic       ready;
   logic       accept;
   src_type    sel [4];

   // segment jobs owed by the held point
   always_comb begin
      job_cnt = 2'd0;
      job.a   = SRC_W0;
      job.b   = SRC_W1;
      job.c   = SRC_W2;
      job.d   = SRC_CUR;
      job.flags = '0;
      if (wrap_ff) begin
         job_cnt = 2'd1;
         job.a = SRC_W2;
         job.b = SRC_H0;
         job.c = SRC_H1;
         job.d = SRC_H2;
         job.flags.last_seg = 1'b1;
      end else if (mode_ff) begin
         if (!item_last_ff) begin
            if (seen_ff >= 3'd3) begin
               job_cnt = 2'd1;
            end
         end else if (seen_ff == 3'd2) begin
            job_cnt = 2'd3;
            case (job_idx_ff)
               2'd0: begin
                  job.a = SRC_H0;
                  job.b = SRC_H1;
                  job.c = SRC_CUR;
                  job.d = SRC_H0;
               end
               2'd1: begin
                  job.a = SRC_H1;
                  job.b = SRC_CUR;
                  job.c = SRC_H0;
                  job.d = SRC_H1;
               end
               default: begin
                  job.a = SRC_CUR;
                  job.b = SRC_H0;
                  job.c = SRC_H1;
                  job.d = SRC_CUR;
                  job.flags.last_seg = 1'b1;
               end
            endcase
         end else if (seen_ff >= 3'd3) begin
            job_cnt = 2'd3;
            case (job_idx_ff)
               2'd0: begin
                  job.a = SRC_W0;
                  job.b = SRC_W1;
                  job.c = SRC_W2;
                  job.d = SRC_CUR;
               end
               2'd1: begin
                  job.a = SRC_W1;
                  job.b = SRC_W2;
                  job.c = SRC_CUR;
                  job.d = SRC_H0;
               end
               default: begin
                  job.a = SRC_W2;
                  job.b = SRC_CUR;
                  job.c = SRC_H0;
                  job.d = SRC_H1;
               end
            endcase
         end
      end else begin
         if (!item_last_ff) begin
            if (seen_ff >= 3'd4) begin
               job_cnt = 2'd1;
               job.a = SRC_OLDER;
               job.b = SRC_W0;
               job.c = SRC_W1;
               job.d = SRC_W2;
               job.flags.first      = (seen_ff == 3'd4);
               job.flags.prev_first = (seen_ff == 3'd5);
            end
         end else if (seen_ff == 3'd3) begin
            job_cnt = 2'd1;
            job.flags.first    = 1'b1;
            job.flags.last     = 1'b1;
            job.flags.last_seg = 1'b1;
         end else if (seen_ff >= 3'd4) begin
            job_cnt = 2'd2;
            if (job_idx_ff == 2'd0) begin
               job.a = SRC_OLDER;
               job.b = SRC_W0;
               job.c = SRC_W1;
               job.d = SRC_W2;
               job.flags.first      = (seen_ff == 3'd4);
               job.flags.prev_first = (seen_ff == 3'd5);
               job.flags.next_last  = 1'b1;
            end else begin
               job.flags.last       = 1'b1;
               job.flags.prev_first = (seen_ff == 3'd4);
               job.flags.last_seg   = 1'b1;
            end
         end
      end
   end

   always_comb begin
      sel[PT_A] = job.a;
      sel[PT_B] = job.b;
      sel[PT_C] = job.c;
      sel[PT_D] = job.d;
      for (int r = 0; r < 4; r++) begin
         unique case (sel[r])
            SRC_OLDER: begin
               job_pt[CRD_X][r] = older_x_ff;
               job_pt[CRD_Y][r] = older_y_ff;
            end
            SRC_W0: begin
               job_pt[CRD_X][r] = win_x_ff[0];
               job_pt[CRD_Y][r] = win_y_ff[0];
            end
            SRC_W1: begin
               job_pt[CRD_X][r] = win_x_ff[1];
               job_pt[CRD_Y][r] = win_y_ff[1];
            end
            SRC_W2: begin
               job_pt[CRD_X][r] = win_x_ff[2];
               job_pt[CRD_Y][r] = win_y_ff[2];
            end
            SRC_H0: begin
               job_pt[CRD_X][r] = head_x_ff[0];
               job_pt[CRD_Y][r] = head_y_ff[0];
            end
            SRC_H1: begin
               job_pt[CRD_X][r] = head_x_ff[1];
               job_pt[CRD_Y][r] = head_y_ff[1];
            end
            SRC_H2: begin
               job_pt[CRD_X][r] = head_x_ff[2];
               job_pt[CRD_Y][r] = head_y_ff[2];
            end
            SRC_CUR: begin
               job_pt[CRD_X][r] = item_x_ff;
               job_pt[CRD_Y][r] = item_y_ff;
            end
         endcase
      end
   end

   assign job_valid = item_valid_ff && (job_cnt != 2'd0);
   assign job_flags = job.flags;
   assign last_job  = (job_idx_ff == (job_cnt - 2'd1));
   assign issue     = job_valid && adv;
   assign done      = item_valid_ff && ((job_cnt == 2'd0) || (issue && last_job));
   assign ready     = !item_valid_ff || done;
   assign accept    = req_valid && ready;

   always_comb begin
      mode_in       = csr_wr_en ? csr_wr_data : mode_ff;
      item_valid_in = accept ? 1'b1 : (done ? 1'b0 : item_valid_ff);
      job_idx_in    = done ? 2'd0 : (issue ? job_idx_ff + 2'd1 : job_idx_ff);
      win_x_in      = win_x_ff;
      win_y_in      = win_y_ff;
      older_x_in    = older_x_ff;
      older_y_in    = older_y_ff;
      head_x_in     = head_x_ff;
      head_y_in     = head_y_ff;
      seen_in       = seen_ff;
      wrap_in       = wrap_ff;
      if (done) begin
         older_x_in  = win_x_ff[0];
         older_y_in  = win_y_ff[0];
         win_x_in    = {item_x_ff, win_x_ff[2], win_x_ff[1]};
         win_y_in    = {item_y_ff, win_y_ff[2], win_y_ff[1]};
         for (int i = 0; i < 3; i++) begin
            if (seen_ff == CNT_W'(i)) begin
               head_x_in[i] = item_x_ff;
               head_y_in[i] = item_y_ff;
            end
         end
         if (item_last_ff) begin
            seen_in = '0;
         end else if (seen_ff != SEEN_MAX) begin
            seen_in = seen_ff + 1'b1;
         end
         wrap_in = mode_ff && item_last_ff && (seen_ff >= 3'd3) && !wrap_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= 1'b0;
         item_valid_ff <= 1'b0;
         job_idx_ff    <= 2'd0;
         seen_ff       <= '0;
         wrap_ff       <= 1'b0;
         win_x_ff      <= '0;
         win_y_ff      <= '0;
         older_x_ff    <= '0;
         older_y_ff    <= '0;
      end else begin
         mode_ff       <= mode_in;
         item_valid_ff <= item_valid_in;
         job_idx_ff    <= job_idx_in;
         seen_ff       <= seen_in;
         wrap_ff       <= wrap_in;
         win_x_ff      <= win_x_in;
         win_y_ff      <= win_y_in;
         older_x_ff    <= older_x_in;
         older_y_ff    <= older_y_in;
      end
   end

   // head store is written before it is read within a spline
   always_ff @(posedge clock) begin
      head_x_ff <= head_x_in;
      head_y_ff <= head_y_in;
      if (accept) begin
         item_x_ff    <= req_point_x;
         item_y_ff    <= req_point_y;
         item_last_ff <= req_last_point;
      end
   end

   assign status.item_valid   = item_valid_ff;
   assign status.item_done    = done;
   assign status.wrap_pending = wrap_ff;
   assign status.seen         = seen_ff;

endmodule

`default_nettype wire
